>>> design/lmsfir_pkg.sv
// Shared constants, widths and types of the LMS adaptive FIR equalizer.
package lmsfir_pkg;

    localparam int DEF_NUM_TAPS = 16;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 16;
    localparam int ERR_W    = 17;
    localparam int WEIGHT_W = 24;

    localparam logic [STEP_W-1:0]   STEP_RESET = 16'd328;
    localparam logic [WEIGHT_W-1:0] W_ONE      = 24'h100000;

    // shared multiplier: A holds a weight, err or mu*err, B a sample or mu
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int FIR_PROD_W = WEIGHT_W + SAMPLE_W;

    localparam int OUT_FRAC = 20;
    localparam int UPD_FRAC = 26;
    localparam int DW_W     = PROD_W - UPD_FRAC;

    typedef struct packed {
        logic mul_en;
        logic accum;
        logic acc_clr;
    } mac_ctrl_t;

endpackage

>>> design/lmsfir_in_if.sv
// Input channel: one received sample and one training sample per transaction.
interface lmsfir_in_if;
    import lmsfir_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic signed [SAMPLE_W-1:0] desired_sample;

    modport source (output valid, output sample_in, output desired_sample, input ready);
    modport sink   (input valid, input sample_in, input desired_sample, output ready);
endinterface

>>> design/lmsfir_out_if.sv
// Output channel: filter output and error per transaction.
interface lmsfir_out_if;
    import lmsfir_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filter_out;
    logic signed [ERR_W-1:0]    error_out;

    modport source (output valid, output filter_out, output error_out, input ready);
    modport sink   (input valid, input filter_out, input error_out, output ready);
endinterface

>>> design/lms_adaptive_fir_equalizer.sv
// A result is registered in the load state once the output register is free, after the
// filter pass and the error and mu*err steps; a new transaction is taken only in idle,
// after the update pass. Each pass reads one tap per cycle through the one shared multiplier.
// Reset: step size 328, delay line zero, weights zero except center tap 1.0;
// valid bits give these values at once, no clearing pass.
module lms_adaptive_fir_equalizer #(
    parameter int NUM_TAPS = lmsfir_pkg::DEF_NUM_TAPS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step_size_we,
    input  logic [lmsfir_pkg::STEP_W-1:0]       step_size,
    lmsfir_in_if.sink                           samples,
    lmsfir_out_if.source                        results
);
    import lmsfir_pkg::*;

    localparam int AW    = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam int ACC_W = FIR_PROD_W + $clog2(NUM_TAPS);
    localparam logic [AW-1:0] LAST = AW'(NUM_TAPS - 1);

    localparam logic signed [ACC_W-1:0]    OUT_HALF = ACC_W'(64'd1 << (OUT_FRAC - 1));
    localparam logic signed [ACC_W-1:0]    Y_MAX    = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0]    Y_MIN    = ~Y_MAX;
    localparam logic signed [PROD_W-1:0]   UPD_HALF = PROD_W'(64'd1 << (UPD_FRAC - 1));
    localparam logic signed [WEIGHT_W+1:0] W_MAX    = (WEIGHT_W+2)'(8388607);
    localparam logic signed [WEIGHT_W+1:0] W_MIN    = ~W_MAX;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FIR  = 4'd1;
    localparam logic [3:0] S_FDRN = 4'd2;
    localparam logic [3:0] S_ERR  = 4'd3;
    localparam logic [3:0] S_MUE  = 4'd4;
    localparam logic [3:0] S_LOAD = 4'd5;
    localparam logic [3:0] S_UPD  = 4'd6;
    localparam logic [3:0] S_UDRN = 4'd7;

    logic [3:0]                 state_reg, state_next;
    logic [STEP_W-1:0]          step_reg;
    logic [AW-1:0]              idx_reg;
    logic [AW-1:0]              daddr_reg;
    logic [AW-1:0]              ptr_reg;
    logic [AW-1:0]              ptr_next;
    logic [1:0]                 drain_reg;
    logic                       ph_upd_reg;
    logic                       rd_v_reg;
    logic                       p_v_reg;
    logic                       dw_v_reg;
    logic [AW-1:0]              addr1_reg, addr2_reg, addr3_reg;
    logic signed [SAMPLE_W-1:0] desired_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [MUL_A_W-1:0]  mue_reg;
    logic signed [WEIGHT_W-1:0] w_p_reg, w_q_reg;
    logic signed [DW_W-1:0]     dw_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_y_reg;
    logic signed [ERR_W-1:0]    out_err_reg;

    logic                       accept;
    logic                       out_free;
    logic [AW-1:0]              daddr_inc;
    logic signed [SAMPLE_W-1:0] d_rdata;
    logic signed [WEIGHT_W-1:0] w_rdata;
    logic signed [WEIGHT_W-1:0] w_wdata;
    logic signed [WEIGHT_W+1:0] w_sum;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    acc_sh;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   p_rnd;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    mac_ctrl_t                  mac_ctrl;

    assign accept    = samples.valid && samples.ready;
    assign out_free  = !out_valid_reg || results.ready;
    assign ptr_next  = (ptr_reg == '0) ? LAST : ptr_reg - AW'(1);
    assign daddr_inc = (daddr_reg == LAST) ? '0 : daddr_reg + AW'(1);

    assign samples.ready     = (state_reg == S_IDLE);
    assign results.valid     = out_valid_reg;
    assign results.filter_out = out_y_reg;
    assign results.error_out = out_err_reg;

    always_comb
    begin
        acc_sh = (acc + OUT_HALF) >>> OUT_FRAC;
        if (acc_sh > Y_MAX)
        begin
            y_sat = SAMPLE_W'(Y_MAX);
        end
        else if (acc_sh < Y_MIN)
        begin
            y_sat = SAMPLE_W'(Y_MIN);
        end
        else
        begin
            y_sat = acc_sh[SAMPLE_W-1:0];
        end
    end

    assign p_rnd = prod + UPD_HALF;

    always_comb
    begin
        w_sum = (WEIGHT_W+2)'(w_q_reg) + (WEIGHT_W+2)'(dw_reg);
        if (w_sum > W_MAX)
        begin
            w_wdata = WEIGHT_W'(W_MAX);
        end
        else if (w_sum < W_MIN)
        begin
            w_wdata = WEIGHT_W'(W_MIN);
        end
        else
        begin
            w_wdata = w_sum[WEIGHT_W-1:0];
        end
    end

    always_comb
    begin
        mac_ctrl.mul_en  = rd_v_reg || (state_reg == S_MUE);
        mac_ctrl.accum   = rd_v_reg && !ph_upd_reg;
        mac_ctrl.acc_clr = accept;
        if (state_reg == S_MUE)
        begin
            mul_a = MUL_A_W'(err_reg);
            mul_b = $signed({1'b0, step_reg});
        end
        else if (ph_upd_reg)
        begin
            mul_a = mue_reg;
            mul_b = MUL_B_W'(d_rdata);
        end
        else
        begin
            mul_a = MUL_A_W'(w_rdata);
            mul_b = MUL_B_W'(d_rdata);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_FIR;
            S_FIR:  if (idx_reg == LAST) state_next = S_FDRN;
            S_FDRN: if (drain_reg == '0) state_next = S_ERR;
            S_ERR:  state_next = S_MUE;
            S_MUE:  state_next = S_LOAD;
            S_LOAD: if (out_free) state_next = S_UPD;
            S_UPD:  if (idx_reg == LAST) state_next = S_UDRN;
            S_UDRN: if (drain_reg == '0) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_RESET;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            daddr_reg     <= '0;
            drain_reg     <= '0;
            ph_upd_reg    <= 1'b0;
            rd_v_reg      <= 1'b0;
            p_v_reg       <= 1'b0;
            dw_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (step_size_we)
            begin
                step_reg <= step_size;
            end
            rd_v_reg <= (state_reg == S_FIR) || (state_reg == S_UPD);
            p_v_reg  <= rd_v_reg;
            dw_v_reg <= p_v_reg && ph_upd_reg;

            if (state_reg == S_FIR || state_reg == S_UPD)
            begin
                idx_reg   <= idx_reg + AW'(1);
                daddr_reg <= daddr_inc;
                drain_reg <= (state_reg == S_FIR) ? 2'd1 : 2'd2;
            end
            else if (drain_reg != '0)
            begin
                drain_reg <= drain_reg - 2'd1;
            end

            if (accept)
            begin
                ptr_reg    <= ptr_next;
                daddr_reg  <= ptr_next;
                idx_reg    <= '0;
                ph_upd_reg <= 1'b0;
            end

            if (state_reg == S_LOAD && out_free)
            begin
                idx_reg       <= '0;
                daddr_reg     <= ptr_reg;
                ph_upd_reg    <= 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (results.valid && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            desired_reg <= samples.desired_sample;
        end
        if (state_reg == S_ERR)
        begin
            err_reg   <= ERR_W'(desired_reg) - ERR_W'(y_sat);
        end
        if (state_reg == S_LOAD && out_free)
        begin
            out_y_reg   <= y_sat;
            out_err_reg <= err_reg;
            mue_reg     <= prod[MUL_A_W-1:0];
        end
        addr1_reg <= idx_reg;
        addr2_reg <= addr1_reg;
        addr3_reg <= addr2_reg;
        w_p_reg   <= w_rdata;
        w_q_reg   <= w_p_reg;
        dw_reg    <= p_rnd[PROD_W-1:UPD_FRAC];
    end

    lmsfir_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod),
        .acc   (acc)
    );

    lmsfir_mem #(
        .NUM_TAPS (NUM_TAPS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .d_we    (accept),
        .d_waddr (ptr_next),
        .d_wdata (samples.sample_in),
        .d_raddr (daddr_reg),
        .d_rdata (d_rdata),
        .w_we    (dw_v_reg),
        .w_waddr (addr3_reg),
        .w_wdata (w_wdata),
        .w_raddr (idx_reg),
        .w_rdata (w_rdata)
    );
endmodule

>>> design/lmsfir_mac.sv
// Shared registered multiplier with accumulator.
module lmsfir_mac #(
    parameter int ACC_W = lmsfir_pkg::FIR_PROD_W + $clog2(lmsfir_pkg::DEF_NUM_TAPS)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lmsfir_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [lmsfir_pkg::MUL_A_W-1:0]  a,
    input  logic signed [lmsfir_pkg::MUL_B_W-1:0]  b,
    output logic signed [lmsfir_pkg::PROD_W-1:0]   prod,
    output logic signed [ACC_W-1:0]                acc
);
    import lmsfir_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     pv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= ctrl.mul_en && ctrl.accum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= a * b;
        end
        if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + $signed(prod_reg[ACC_W-1:0]);
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;
endmodule

>>> design/lmsfir_mem.sv
// Delay-line and tap-weight memories with per-entry valid bits for reset values.
module lmsfir_mem #(
    parameter  int NUM_TAPS = lmsfir_pkg::DEF_NUM_TAPS,
    localparam int AW       = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    d_we,
    input  logic [AW-1:0]                           d_waddr,
    input  logic signed [lmsfir_pkg::SAMPLE_W-1:0]  d_wdata,
    input  logic [AW-1:0]                           d_raddr,
    output logic signed [lmsfir_pkg::SAMPLE_W-1:0]  d_rdata,
    input  logic                                    w_we,
    input  logic [AW-1:0]                           w_waddr,
    input  logic signed [lmsfir_pkg::WEIGHT_W-1:0]  w_wdata,
    input  logic [AW-1:0]                           w_raddr,
    output logic signed [lmsfir_pkg::WEIGHT_W-1:0]  w_rdata
);
    import lmsfir_pkg::*;

    localparam logic [AW-1:0] CENTER = AW'(NUM_TAPS / 2);

    logic signed [SAMPLE_W-1:0] dmem [NUM_TAPS];
    logic signed [WEIGHT_W-1:0] wmem [NUM_TAPS];
    logic [NUM_TAPS-1:0]        d_vld_reg;
    logic [NUM_TAPS-1:0]        w_vld_reg;
    logic signed [SAMPLE_W-1:0] d_rdata_reg;
    logic signed [WEIGHT_W-1:0] w_rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= '0;
            w_vld_reg <= '0;
        end
        else
        begin
            if (d_we)
            begin
                d_vld_reg[d_waddr] <= 1'b1;
            end
            if (w_we)
            begin
                w_vld_reg[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            dmem[d_waddr] <= d_wdata;
        end
        if (w_we)
        begin
            wmem[w_waddr] <= w_wdata;
        end
        d_rdata_reg <= d_vld_reg[d_raddr] ? dmem[d_raddr] : '0;
        if (w_vld_reg[w_raddr])
        begin
            w_rdata_reg <= wmem[w_raddr];
        end
        else
        begin
            w_rdata_reg <= (w_raddr == CENTER) ? $signed(W_ONE) : '0;
        end
    end

    assign d_rdata = d_rdata_reg;
    assign w_rdata = w_rdata_reg;
endmodule
